>>> sv/hmbd_pkg.sv
// shared types, address constants and the address decoder of the memory bus
package hmbd_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [15:0] ADDR_P1   = 16'hFF00;
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;

  localparam logic [7:0] PAGE_OAM  = 8'hFE;
  localparam logic [7:0] PAGE_HIGH = 8'hFF;

  localparam logic [7:0] P1_RESET   = 8'hC0;
  localparam logic [7:0] LCDC_RESET = 8'h91;

  typedef enum logic [2:0] {
    RG_CART,
    RG_VRAM,
    RG_WRAM,
    RG_OAM,
    RG_HOLE,
    RG_HIGH
  } region_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DMA_CHK,
    ST_DMA_WR
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  cycles;
    logic        blank;
    logic [3:0]  dpad;
    logic [3:0]  act;
    region_e     region;
    logic        hram;
  } item_t;

  function automatic region_e classify(logic [15:0] a);
    region_e r;
    if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) r = RG_CART;
    else if (a <= 16'h9FFF) r = RG_VRAM;
    else if (a >= 16'hC000 && a <= 16'hFDFF) r = RG_WRAM;
    else if (a >= 16'hFE00 && a <= 16'hFE9F) r = RG_OAM;
    else if (a <= 16'hFEFF || (a >= 16'hFF4C && a <= 16'hFF7F)) r = RG_HOLE;
    else r = RG_HIGH;
    return r;
  endfunction

endpackage

>>> sv/handheld_memory_bus_with_oam_dma.sv
// top level of the handheld memory bus with oam dma
// usage:
// - one request per cpu access: command 0 read, 1 write, 2 tick of elapsed cycles
// - input channel in_valid_i/in_ready_o, result channel out_valid_o/out_ready_i
// - exactly one result per request, in request order
// request flow:
// - a request is registered in the front queue, then the back end runs it
// - writes, refused and cart accesses and idle ticks: result set on pop
// - reads: via the read state (registered memory read)
// - a tick while the dma runs copies oam bytes, each read in the dma check
//   state and then written through the single oam write port
// - the back end takes a new request only when the result register is empty,
//   so it takes no new request before the last result has been taken
// reset:
// - after reset a clearing pass zeroes vram, wram, oam and the high page,
//   during which in_ready_o stays low
// stall:
// - a stalled result holds; up to two requests queue in front of it
module handheld_memory_bus_with_oam_dma
  import hmbd_pkg::*;
#(
  parameter int DMA_LENGTH      = 160,
  parameter int CYCLES_PER_BYTE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  tick_cycles_i,
  input  logic        ppu_in_blank_i,
  input  logic [3:0]  dpad_pressed_i,
  input  logic [3:0]  action_pressed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        access_refused_o,
  output logic        cart_access_o,
  output logic        dma_busy_o
);

  // queue between decode and execution
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  clearing;

  hmbd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .tick_cycles_i    (tick_cycles_i),
    .ppu_in_blank_i   (ppu_in_blank_i),
    .dpad_pressed_i   (dpad_pressed_i),
    .action_pressed_i (action_pressed_i),
    .clearing_i       (clearing),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  // execution, memories and dma copy
  hmbd_back #(
    .DMA_LENGTH      (DMA_LENGTH),
    .CYCLES_PER_BYTE (CYCLES_PER_BYTE)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .clearing_o       (clearing),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .access_refused_o (access_refused_o),
    .cart_access_o    (cart_access_o),
    .dma_busy_o       (dma_busy_o)
  );

endmodule

>>> sv/hmbd_front.sv
// front end: accepts requests, decodes the region and queues them
module hmbd_front
  import hmbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  tick_cycles_i,
  input  logic        ppu_in_blank_i,
  input  logic [3:0]  dpad_pressed_i,
  input  logic [3:0]  action_pressed_i,
  input  logic        clearing_i,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  item_t       new_item;

  assign in_ready_o = (count_q != 2'd2) && !clearing_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    new_item.cmd    = command_i;
    new_item.addr   = address_i;
    new_item.wdata  = write_data_i;
    new_item.cycles = tick_cycles_i;
    new_item.blank  = ppu_in_blank_i;
    new_item.dpad   = dpad_pressed_i;
    new_item.act    = action_pressed_i;
    new_item.region = classify(address_i);
    new_item.hram   = (address_i >= 16'hFF80) && (address_i <= 16'hFFFE);
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> sv/hmbd_back.sv
// back end: memories, register file, dma engine and result register
module hmbd_back
  import hmbd_pkg::*;
#(
  parameter int DMA_LENGTH      = 160,
  parameter int CYCLES_PER_BYTE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        clearing_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        access_refused_o,
  output logic        cart_access_o,
  output logic        dma_busy_o
);

  localparam logic [8:0]  LEN = 9'(DMA_LENGTH);
  localparam logic [15:0] CPB = 16'(CYCLES_PER_BYTE);

  logic [7:0] vram [8192];
  logic [7:0] wram [8192];
  logic [7:0] oam  [256];
  logic [7:0] hi   [256];

  state_e      state_q, state_d;
  logic [12:0] clr_q, clr_d;
  logic        running_q, running_d;
  logic [7:0]  page_q, page_d;
  logic [8:0]  idx_q, idx_d;
  logic [15:0] credit_q, credit_d;
  logic [7:0]  p1_q, p1_d, lcdc_q, lcdc_d, stat_q, stat_d;
  item_t       hold_q, hold_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        refused_q, refused_d, cart_q, cart_d, busy_q, busy_d;

  logic [15:0] rd_addr, raw_addr;
  logic [7:0]  vram_rd_q, wram_rd_q, oam_rd_q, hi_rd_q;
  logic        vram_we, wram_we, oam_we, hi_we;
  logic [12:0] wa;
  logic [7:0]  wd;
  logic [7:0]  raw_byte, rd_val;
  logic        pop, is_access, refused, ok, cart, more, push;
  logic [16:0] credit_sum;

  assign pop       = (state_q == ST_IDLE) && q_valid_i && !out_valid_q;
  assign q_pop_o   = pop;
  assign clearing_o = (state_q == ST_CLEAR);
  assign is_access = (q_item_i.cmd == CMD_READ) || (q_item_i.cmd == CMD_WRITE);
  assign refused   = is_access && running_q && !q_item_i.hram;
  assign ok        = is_access && !refused;
  assign cart      = ok && (q_item_i.region == RG_CART);
  assign more      = (idx_q < LEN) && (credit_q >= CPB);
  assign credit_sum = {1'b0, credit_q} + {9'd0, q_item_i.cycles};

  // memory read address: dma source in the dma check state, cpu item otherwise
  always_comb begin
    rd_addr  = (state_q == ST_DMA_CHK) ? {page_q, idx_q[7:0]} : q_item_i.addr;
    raw_addr = (state_q == ST_READ) ? hold_q.addr : {page_q, idx_q[7:0]};
  end

  always_ff @(posedge clk_i) begin
    if (vram_we) vram[wa] <= wd;
    vram_rd_q <= vram[rd_addr[12:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wram_we) wram[wa] <= wd;
    wram_rd_q <= wram[rd_addr[12:0]];
  end

  always_ff @(posedge clk_i) begin
    if (oam_we) oam[wa[7:0]] <= wd;
    oam_rd_q <= oam[rd_addr[7:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hi_we) hi[wa[7:0]] <= wd;
    hi_rd_q <= hi[rd_addr[7:0]];
  end

  // raw stored byte at raw_addr
  always_comb begin
    if (raw_addr[15:8] == PAGE_OAM) begin
      raw_byte = oam_rd_q;
    end else if (raw_addr[15:8] == PAGE_HIGH) begin
      if (raw_addr == ADDR_P1) raw_byte = p1_q;
      else if (raw_addr == ADDR_LCDC) raw_byte = lcdc_q;
      else if (raw_addr == ADDR_STAT) raw_byte = stat_q;
      else if (raw_addr == ADDR_LY) raw_byte = 8'h00;
      else raw_byte = hi_rd_q;
    end else begin
      unique case (classify(raw_addr))
        RG_VRAM: raw_byte = vram_rd_q;
        RG_WRAM: raw_byte = wram_rd_q;
        default: raw_byte = 8'h00;
      endcase
    end
  end

  // cpu view of a read
  always_comb begin
    if (hold_q.addr == ADDR_P1) begin
      if (!p1_q[4]) rd_val = {4'h0, ~hold_q.dpad};
      else if (!p1_q[5]) rd_val = {4'h0, ~hold_q.act};
      else rd_val = 8'h00;
    end else if (hold_q.region == RG_OAM) begin
      rd_val = hold_q.blank ? raw_byte : 8'hFF;
    end else if (hold_q.region == RG_HOLE) begin
      rd_val = 8'hFF;
    end else begin
      rd_val = raw_byte;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pop) begin
          if (q_item_i.cmd == CMD_READ && ok && !cart) state_d = ST_READ;
          else if (q_item_i.cmd == CMD_TICK && running_q) state_d = ST_DMA_CHK;
        end
      end
      ST_READ:    state_d = ST_IDLE;
      ST_DMA_CHK: state_d = more ? ST_DMA_WR : ST_IDLE;
      ST_DMA_WR:  state_d = ST_DMA_CHK;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    clr_d     = clr_q;
    running_d = running_q;
    page_d    = page_q;
    idx_d     = idx_q;
    credit_d  = credit_q;
    p1_d      = p1_q;
    lcdc_d    = lcdc_q;
    stat_d    = stat_q;
    hold_d    = hold_q;
    vram_we   = 1'b0;
    wram_we   = 1'b0;
    oam_we    = 1'b0;
    hi_we     = 1'b0;
    wa        = q_item_i.addr[12:0];
    wd        = q_item_i.wdata;
    push      = 1'b0;
    rdata_d   = 8'h00;
    refused_d = 1'b0;
    cart_d    = 1'b0;
    busy_d    = running_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d   = clr_q + 13'd1;
        vram_we = 1'b1;
        wram_we = 1'b1;
        oam_we  = 1'b1;
        hi_we   = 1'b1;
        wa      = clr_q;
        wd      = 8'h00;
      end
      ST_IDLE: begin
        if (pop) begin
          hold_d = q_item_i;
          if (q_item_i.cmd == CMD_WRITE && ok && !cart) begin
            unique case (q_item_i.region)
              RG_VRAM: vram_we = 1'b1;
              RG_WRAM: wram_we = 1'b1;
              RG_OAM:  oam_we  = 1'b1;
              RG_HIGH: begin
                if (q_item_i.addr == ADDR_P1) begin
                  p1_d = q_item_i.wdata;
                end else if (q_item_i.addr == ADDR_STAT) begin
                  stat_d = q_item_i.wdata;
                end else if (q_item_i.addr == ADDR_LCDC) begin
                  // display enable toggle drops the stat mode bits
                  if (q_item_i.wdata[7] != lcdc_q[7]) stat_d = {stat_q[7:2], 2'b00};
                  lcdc_d = q_item_i.wdata;
                end else if (q_item_i.addr == ADDR_DMA) begin
                  running_d = 1'b1;
                  page_d    = q_item_i.wdata;
                  idx_d     = 9'd0;
                  credit_d  = 16'd0;
                end else if (q_item_i.addr != ADDR_DIV && q_item_i.addr != ADDR_LY &&
                             q_item_i.addr != ADDR_TAC) begin
                  hi_we = 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (q_item_i.cmd == CMD_TICK && running_q) begin
            credit_d = credit_sum[16] ? 16'hFFFF : credit_sum[15:0];
          end else if (!(q_item_i.cmd == CMD_READ && ok && !cart)) begin
            push      = 1'b1;
            refused_d = refused;
            cart_d    = cart;
            busy_d    = running_d;
          end
        end
      end
      ST_READ: begin
        push    = 1'b1;
        rdata_d = rd_val;
      end
      ST_DMA_CHK: begin
        if (!more) begin
          if (idx_q >= LEN) running_d = 1'b0;
          push   = 1'b1;
          busy_d = (idx_q < LEN);
        end
      end
      ST_DMA_WR: begin
        oam_we   = 1'b1;
        wa       = {5'd0, idx_q[7:0]};
        wd       = raw_byte;
        idx_d    = idx_q + 9'd1;
        credit_d = credit_q - CPB;
      end
      default: ;
    endcase
    if (push) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (push) begin
      rdata_q   <= rdata_d;
      refused_q <= refused_d;
      cart_q    <= cart_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= 13'd0;
      running_q   <= 1'b0;
      page_q      <= 8'h00;
      idx_q       <= 9'd0;
      credit_q    <= 16'd0;
      p1_q        <= P1_RESET;
      lcdc_q      <= LCDC_RESET;
      stat_q      <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      running_q   <= running_d;
      page_q      <= page_d;
      idx_q       <= idx_d;
      credit_q    <= credit_d;
      p1_q        <= p1_d;
      lcdc_q      <= lcdc_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rdata_q;
  assign access_refused_o = refused_q;
  assign cart_access_o    = cart_q;
  assign dma_busy_o       = busy_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LEN) else $error("dma index past length");

  a_wr_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DMA_WR) |-> running_q) else $error("dma copy while idle");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !out_valid_q) else $error("pop with result pending");

  a_credit_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && running_q) |-> (credit_q < CPB))
    else $error("credit left unspent");

endmodule
